// ----- rtl/core/bia_pkg.sv -----
`default_nettype none

package bia_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = 16;
    localparam int TOTAL_IDS  = WORD_BITS * WORD_COUNT;
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam int KIND_W    = 2;
    localparam int ID_W      = 10;
    localparam int STAT_W    = 2;
    localparam int HM_W      = 11;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_CLAIM   = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BUSY     = 2'd1,
        STAT_FREE_REL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_CLAIM,
        S_REL,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        word_t            wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        status_t         status;
        logic [HM_W-1:0] high_mark;
    } result_t;

    // position of the lowest clear bit; zero if the word is full
    function automatic logic [OFF_W-1:0] lowest_zero(input word_t w);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = OFF_W'(i);
            end
        end
        return pos;
    endfunction

    // position of the highest set bit; zero if the word is empty
    function automatic logic [OFF_W-1:0] highest_one(input word_t w);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                pos = OFF_W'(i);
            end
        end
        return pos;
    endfunction

    // ones at bit positions off and below
    function automatic word_t low_mask(input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] sh;
        sh = OFF_W'(WORD_BITS - 1) - off;
        return word_t'('1) >> sh;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bia_word_ram.sv -----
`default_nettype none

module bia_word_ram (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bia_pkg::ram_req_t req,
    output bia_pkg::word_t        rd_data
);
    import bia_pkg::*;

    word_t                 word_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] valid_reg;
    word_t                 rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            word_mem[req.wr_addr] <= req.wr_data;
        end
        // a word never written since reset reads as all free
        if (req.rd_en) begin
            rd_data_reg <= valid_reg[req.rd_addr] ? word_mem[req.rd_addr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bia_ctrl.sv -----
`default_nettype none

module bia_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [bia_pkg::KIND_W-1:0] in_kind,
    input  wire logic [bia_pkg::ID_W-1:0]   in_target,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output bia_pkg::result_t                res,
    output bia_pkg::ram_req_t               ram_req,
    input  wire bia_pkg::word_t             rd_data
);
    import bia_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [HM_W-1:0]  top_reg, top_next;
    logic [ID_W-1:0]  res_id_reg, res_id_next;
    status_t          res_stat_reg, res_stat_next;

    kind_t            kind;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    logic [OFF_W-1:0] in_off;
    logic             last_word;
    logic             first_word;

    logic             alloc_hit;
    logic [OFF_W-1:0] alloc_off;
    logic [ID_W-1:0]  alloc_id;
    logic [ID_W-1:0]  cur_id;
    logic [HM_W-1:0]  cur_plus;
    logic             tgt_bit;
    logic             is_top;
    word_t            rel_word;
    word_t            rel_low;
    logic             rel_found;
    logic [OFF_W-1:0] rel_pos;
    logic             scan_found;
    logic [OFF_W-1:0] scan_pos;

    assign kind     = kind_t'(in_kind);
    assign in_range = HM_W'(in_target) < HM_W'(TOTAL_IDS);
    assign in_idx   = in_target[OFF_W +: IDX_W];
    assign in_off   = in_target[OFF_W-1:0];

    assign last_word  = idx_reg == IDX_W'(WORD_COUNT - 1);
    assign first_word = idx_reg == '0;

    assign alloc_hit = rd_data != word_t'('1);
    assign alloc_off = lowest_zero(rd_data);
    assign alloc_id  = ID_W'({idx_reg, alloc_off});
    assign cur_id    = ID_W'({idx_reg, off_reg});
    assign cur_plus  = HM_W'(cur_id) + HM_W'(1);
    assign tgt_bit   = rd_data[off_reg];
    assign is_top    = top_reg == cur_plus;

    assign rel_word   = rd_data & ~(word_t'(1) << off_reg);
    assign rel_low    = rel_word & low_mask(off_reg);
    assign rel_found  = |rel_low;
    assign rel_pos    = highest_one(rel_low);
    assign scan_found = |rd_data;
    assign scan_pos   = highest_one(rd_data);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (kind)
                        KIND_ALLOC:   state_next = S_ALLOC;
                        KIND_CLAIM:   state_next = in_range ? S_CLAIM : S_DONE;
                        KIND_RELEASE: state_next = in_range ? S_REL : S_DONE;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_ALLOC: begin
                if (alloc_hit || last_word) begin
                    state_next = S_DONE;
                end
            end
            S_CLAIM: state_next = S_DONE;
            S_REL: begin
                if (!tgt_bit || !is_top || rel_found || first_word) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_found || first_word) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        off_next      = off_reg;
        top_next      = top_reg;
        res_id_next   = res_id_reg;
        res_stat_next = res_stat_reg;
        ram_req       = '0;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    idx_next      = (kind == KIND_ALLOC) ? '0 : in_idx;
                    off_next      = in_off;
                    res_id_next   = '0;
                    res_stat_next = STAT_OK;
                    ram_req.rd_addr = idx_next;
                    unique case (kind)
                        KIND_ALLOC: begin
                            ram_req.rd_en = 1'b1;
                        end
                        KIND_CLAIM: begin
                            ram_req.rd_en = in_range;
                            if (!in_range) begin
                                res_stat_next = STAT_BUSY;
                            end
                        end
                        KIND_RELEASE: begin
                            ram_req.rd_en = in_range;
                            if (!in_range) begin
                                res_stat_next = STAT_FREE_REL;
                            end
                        end
                        default: begin
                            ram_req.rd_en = 1'b0;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (alloc_hit) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = idx_reg;
                    ram_req.wr_data = rd_data | (word_t'(1) << alloc_off);
                    res_id_next     = alloc_id;
                    if (HM_W'(alloc_id) >= top_reg) begin
                        top_next = HM_W'(alloc_id) + HM_W'(1);
                    end
                end else if (last_word) begin
                    res_stat_next = STAT_BUSY;
                end else begin
                    // advance to the next word
                    idx_next        = idx_reg + IDX_W'(1);
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_next;
                end
            end
            S_CLAIM: begin
                if (tgt_bit) begin
                    res_stat_next = STAT_BUSY;
                end else begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = idx_reg;
                    ram_req.wr_data = rd_data | (word_t'(1) << off_reg);
                    res_id_next     = cur_id;
                    if (HM_W'(cur_id) >= top_reg) begin
                        top_next = cur_plus;
                    end
                end
            end
            S_REL: begin
                if (!tgt_bit) begin
                    res_stat_next = STAT_FREE_REL;
                end else begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = idx_reg;
                    ram_req.wr_data = rel_word;
                    res_id_next     = cur_id;
                    if (is_top) begin
                        if (rel_found) begin
                            top_next = HM_W'({idx_reg, rel_pos}) + HM_W'(1);
                        end else if (first_word) begin
                            top_next = '0;
                        end else begin
                            // walk down to the lower words
                            idx_next        = idx_reg - IDX_W'(1);
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = idx_next;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (scan_found) begin
                    top_next = HM_W'({idx_reg, scan_pos}) + HM_W'(1);
                end else if (first_word) begin
                    top_next = '0;
                end else begin
                    idx_next        = idx_reg - IDX_W'(1);
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_next;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        off_reg      <= off_next;
        res_id_reg   <= res_id_next;
        res_stat_reg <= res_stat_next;
    end

    assign res.granted_id = res_id_reg;
    assign res.status     = res_stat_reg;
    assign res.high_mark  = top_reg;

    a_no_rw_same_word: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
        else $error("read and write of the same word in one cycle");

    a_fail_has_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status != STAT_OK |-> res.granted_id == '0)
        else $error("failed request carries a nonzero id");

    a_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= HM_W'(TOTAL_IDS))
        else $error("high mark beyond id space");

    a_write_ends_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en && !ram_req.rd_en |=> state_reg == S_DONE)
        else $error("bitmap write without finishing the request");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !res_ready
            |=> state_reg == S_DONE && $stable(res_id_reg) && $stable(top_reg))
        else $error("pending result changed while held");

endmodule

`default_nettype wire

// ----- rtl/core/bitmap_id_allocator.sv -----
// Identifier allocator over a bitmap of WORD_COUNT words of WORD_BITS bits.
// Slave channel (s_): one request per transfer; kind selects allocate the
// lowest free id, claim target_id or release target_id.
// Master channel (m_): exactly one result per request, in request order:
// granted_id, status (ok, busy/full, release of a free id) and high_mark,
// one past the highest id in use after the request.
// One request is worked at a time. The bitmap sits in a memory with one
// read and one write port and a registered read; allocate walks it upward
// and a release of the highest id walks it downward, one word per cycle.
// Allocate examines up to WORD_COUNT words; a release rebuilds the high
// mark from the lower words only when it frees the highest id and no
// lower id in the same word is in use. A new request is taken in the
// cycle after the previous result has moved to the output register.
// The output register holds a result while m_tready is low; the next result
// waits inside the block and s_tready stays low until it can move on.
// Reset (aresetn low, synchronous) marks every id free and the high mark
// zero at once; requests are taken in the first cycle after reset.
`default_nettype none

module bitmap_id_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] kind, [11:2] target_id, rest zero
    input  wire logic [bia_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [9:0] granted_id, [11:10] status, [22:12] high_mark, rest zero
    output logic [bia_pkg::M_TDATA_W-1:0]      m_tdata
);
    import bia_pkg::*;

    ram_req_t              ram_req;
    word_t                 rd_data;
    result_t               res;
    logic                  res_valid;
    logic                  res_ready;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    bia_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .in_kind   (s_tdata[KIND_W-1:0]),
        .in_target (s_tdata[KIND_W +: ID_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    bia_word_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_tdata_next = M_TDATA_W'({res.high_mark, res.status, res.granted_id});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
